[hdl/block_buffer_cache_directory_unit_macros.svh]
// ----------------------------------------------------------------------------
// Buffer cache directory assertion macros
// Shared assertion wrappers for the directory RTL.
// ----------------------------------------------------------------------------
`ifndef BLOCK_BUFFER_CACHE_DIRECTORY_UNIT_MACROS_SVH
`define BLOCK_BUFFER_CACHE_DIRECTORY_UNIT_MACROS_SVH

// implication checked every clock, quiet during reset
`define BBCD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BBCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/bbcd_pkg.sv]
// ----------------------------------------------------------------------------
// Buffer cache directory package
// Constants and item types shared by the directory RTL.
// ----------------------------------------------------------------------------
package bbcd_pkg;

   localparam int NBUF        = 64;
   localparam int MAX_WAITERS = 16;
   localparam int IDX_W       = $clog2(NBUF);
   localparam int CNT_W       = $clog2(NBUF + 1);
   localparam int WAIT_W      = $clog2(MAX_WAITERS + 1);
   localparam logic [7:0] COUNT_MAX = 8'd255;

   localparam logic [0:0] CMD_ACQUIRE = 1'b0;
   localparam logic [0:0] CMD_RELEASE = 1'b1;

   localparam logic [2:0] ST_HIT       = 3'd0;
   localparam logic [2:0] ST_MISS      = 3'd1;
   localparam logic [2:0] ST_NOBUF     = 3'd2;
   localparam logic [2:0] ST_RELEASED  = 3'd3;
   localparam logic [2:0] ST_UNDERFLOW = 3'd4;
   localparam logic [2:0] ST_OVERFLOW  = 3'd5;

   typedef struct packed {
      logic [0:0]  cmd;
      logic [7:0]  dev_id;
      logic [31:0] block_no;
      logic [5:0]  buf_sel;
      logic        was_dirty;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  buf_out;
      logic        read_req;
      logic        write_req;
      logic [7:0]  req_dev;
      logic [31:0] req_block;
      logic        wake_one;
   } rsp_item_type;

endpackage

[hdl/bbcd_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bbcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

[hdl/block_buffer_cache_directory_unit.sv]
// ----------------------------------------------------------------------------
// Block buffer cache directory
// LRU directory of a disk block buffer cache, one shared sequencer.
// ----------------------------------------------------------------------------
// Each item is taken on start while busy is low. busy stays high while the
// item is worked on and drops in the cycle that strobes its one result on
// rsp_valid; results cannot be held off, and the next item may be taken at
// the edge that ends the strobe cycle. An acquire walks all NBUF tag entries
// through one RAM read port and one compare, one entry a cycle. A miss with
// all buffers used walks the entries again to find the oldest free buffer,
// and every change to the free list (take or push) walks the entries once
// more to shift ranks. The tag, rank and count stores are RAMs; the valid
// and free flags are flops.
// ----------------------------------------------------------------------------
module block_buffer_cache_directory_unit
   import bbcd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_valid,
   output rsp_item_type rsp_item
);

`include "block_buffer_cache_directory_unit_macros.svh"

   typedef enum logic [3:0] {
      S_IDLE,
      S_SRCH,    // tag search, one entry per cycle
      S_HITCHK,
      S_LRU,     // oldest free buffer search, or rank fetch of a hit buffer
      S_TAKE,    // rank shift after taking off the list
      S_PUSH,    // rank shift after pushing onto the list
      S_RELRD,   // wait for tag and count read on release
      S_DONE
   } state_type;

   state_type state_ff;
   req_item_type rq_ff;
   rsp_item_type rs_ff;
   logic rsp_valid_ff;

   // sweep index; one bit wider to mark the end
   logic [IDX_W:0] idx_ff;
   logic [IDX_W-1:0] rd_idx;      // address presented to RAMs
   logic [IDX_W-1:0] chk_ff;      // index whose data arrives this cycle
   logic chk_vld_ff;
   logic [IDX_W-1:0] ck;

   logic found_ff;
   logic [IDX_W-1:0] buf_ff;
   logic [IDX_W-1:0] best_age_ff;
   logic got_ff;
   logic [IDX_W-1:0] gone_ff;     // rank of buffer taken off the list
   logic [7:0] cnt_ff;            // count of the matching buffer

   logic [NBUF-1:0] valid_ff;
   logic [NBUF-1:0] free_ff;
   logic [CNT_W-1:0] used_ff;
   logic [WAIT_W-1:0] wait_ff;

   // RAM ports
   logic tag_we;
   logic [IDX_W-1:0] tag_wa;
   logic [39:0] tag_wd, tag_rd;
   logic age_we;
   logic [IDX_W-1:0] age_wa;
   logic [IDX_W-1:0] age_wd, age_rd;
   logic ref_we_ff;
   logic [IDX_W-1:0] ref_wa_ff;
   logic [7:0] ref_wd_ff, ref_rd;

   bbcd_ram #(.WIDTH(40), .DEPTH(NBUF)) u_tag (
      .clock(clock), .wr_en(tag_we), .wr_addr(tag_wa), .wr_data(tag_wd),
      .rd_addr(rd_idx), .rd_data(tag_rd));

   bbcd_ram #(.WIDTH(IDX_W), .DEPTH(NBUF)) u_age (
      .clock(clock), .wr_en(age_we), .wr_addr(age_wa), .wr_data(age_wd),
      .rd_addr(rd_idx), .rd_data(age_rd));

   // reference counts; the read value is used only for valid entries
   bbcd_ram #(.WIDTH(8), .DEPTH(NBUF)) u_ref (
      .clock(clock), .wr_en(ref_we_ff), .wr_addr(ref_wa_ff), .wr_data(ref_wd_ff),
      .rd_addr(rd_idx), .rd_data(ref_rd));

   assign rd_idx = (state_ff == S_RELRD) ? rq_ff.buf_sel[IDX_W-1:0] : idx_ff[IDX_W-1:0];
   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rs_ff;

   assign ck = chk_ff;

   // rank writes happen on the shift sweeps and when a buffer is pushed
   always_comb begin
      age_we = 1'b0;
      age_wa = ck;
      age_wd = age_rd;
      if (chk_vld_ff && free_ff[ck] && (ck != buf_ff)) begin
         if (state_ff == S_TAKE && age_rd > gone_ff) begin
            age_we = 1'b1;
            age_wd = age_rd - IDX_W'(1);
         end else if (state_ff == S_PUSH) begin
            age_we = 1'b1;
            age_wd = age_rd + IDX_W'(1);
         end
      end
      if (state_ff == S_PUSH && chk_vld_ff && ck == buf_ff) begin
         age_we = 1'b1;
         age_wd = '0;
      end
   end

   always_comb begin
      tag_we = (state_ff == S_DONE) && (rs_ff.status == ST_MISS) && !rsp_valid_ff;
      tag_wa = buf_ff;
      tag_wd = {rq_ff.dev_id, rq_ff.block_no};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         free_ff      <= '0;
         used_ff      <= '0;
         wait_ff      <= '0;
         chk_vld_ff   <= 1'b0;
         ref_we_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         chk_ff       <= idx_ff[IDX_W-1:0];
         chk_vld_ff   <= 1'b0;
         ref_we_ff    <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  rq_ff    <= req_item;
                  rs_ff    <= '0;
                  idx_ff   <= '0;
                  found_ff <= 1'b0;
                  got_ff   <= 1'b0;
                  if (req_item.cmd == CMD_ACQUIRE) begin
                     state_ff <= S_SRCH;
                  end else begin
                     rs_ff.buf_out <= req_item.buf_sel;
                     buf_ff        <= req_item.buf_sel[IDX_W-1:0];
                     state_ff      <= S_RELRD;
                  end
               end
            end
            S_SRCH: begin
               if (chk_vld_ff && !found_ff && valid_ff[ck] &&
                   tag_rd == {rq_ff.dev_id, rq_ff.block_no}) begin
                  found_ff <= 1'b1;
                  buf_ff   <= ck;
                  cnt_ff   <= ref_rd;
               end
               if (idx_ff[IDX_W]) begin
                  state_ff <= S_HITCHK;
               end else begin
                  chk_vld_ff <= 1'b1;
                  idx_ff     <= idx_ff + (IDX_W+1)'(1);
               end
            end
            S_HITCHK: begin
               idx_ff <= '0;
               if (found_ff) begin
                  rs_ff.buf_out <= 6'(buf_ff);
                  if (cnt_ff >= COUNT_MAX) begin
                     rs_ff.status <= ST_OVERFLOW;
                     state_ff     <= S_DONE;
                  end else begin
                     ref_we_ff    <= 1'b1;
                     ref_wa_ff    <= buf_ff;
                     ref_wd_ff    <= cnt_ff + 8'd1;
                     rs_ff.status <= ST_HIT;
                     if (free_ff[buf_ff]) begin
                        // fetch the rank of the hit buffer first
                        idx_ff   <= {1'b0, buf_ff};
                        got_ff   <= 1'b1;
                        best_age_ff <= '0;
                        state_ff <= S_LRU;
                     end else begin
                        state_ff <= S_DONE;
                     end
                  end
               end else if (used_ff < CNT_W'(NBUF)) begin
                  buf_ff        <= used_ff[IDX_W-1:0];
                  used_ff       <= used_ff + CNT_W'(1);
                  state_ff      <= S_DONE;
                  rs_ff.status  <= ST_MISS;
                  rs_ff.buf_out <= 6'(used_ff[IDX_W-1:0]);
                  rs_ff.read_req <= 1'b1;
                  rs_ff.req_dev  <= rq_ff.dev_id;
                  rs_ff.req_block <= rq_ff.block_no;
                  valid_ff[used_ff[IDX_W-1:0]] <= 1'b1;
                  ref_we_ff <= 1'b1;
                  ref_wa_ff <= used_ff[IDX_W-1:0];
                  ref_wd_ff <= 8'd1;
               end else begin
                  chk_vld_ff <= 1'b1;
                  idx_ff     <= (IDX_W+1)'(1);
                  state_ff   <= S_LRU;
               end
            end
            S_LRU: begin
               if (found_ff) begin
                  // hit path: rank of buf_ff arrives in the cycle after its address
                  if (got_ff) begin
                     got_ff <= 1'b0;
                  end else begin
                     gone_ff    <= age_rd;
                     free_ff[buf_ff] <= 1'b0;
                     idx_ff     <= '0;
                     state_ff   <= S_TAKE;
                  end
               end else begin
                  if (chk_vld_ff && free_ff[ck] && (!got_ff || age_rd > best_age_ff)) begin
                     got_ff      <= 1'b1;
                     best_age_ff <= age_rd;
                     buf_ff      <= ck;
                  end
                  if (idx_ff[IDX_W]) begin
                     if (got_ff || (chk_vld_ff && free_ff[ck])) begin
                        // buf_ff and best settle this cycle; take next
                        found_ff <= 1'b0;
                        got_ff   <= 1'b1;
                        state_ff <= S_TAKE;
                        idx_ff   <= '0;
                        gone_ff  <= (chk_vld_ff && free_ff[ck] &&
                                     (!got_ff || age_rd > best_age_ff)) ? age_rd : best_age_ff;
                        if (chk_vld_ff && free_ff[ck] && (!got_ff || age_rd > best_age_ff))
                           free_ff[ck] <= 1'b0;
                        else
                           free_ff[buf_ff] <= 1'b0;
                        rs_ff.status   <= ST_MISS;
                        rs_ff.read_req <= 1'b1;
                        rs_ff.req_dev  <= rq_ff.dev_id;
                        rs_ff.req_block <= rq_ff.block_no;
                     end else begin
                        rs_ff.status <= ST_NOBUF;
                        if (wait_ff < WAIT_W'(MAX_WAITERS)) begin
                           wait_ff <= wait_ff + WAIT_W'(1);
                        end
                        state_ff <= S_DONE;
                     end
                  end else begin
                     chk_vld_ff <= 1'b1;
                     idx_ff     <= idx_ff + (IDX_W+1)'(1);
                  end
               end
            end
            S_TAKE: begin
               // first cycle addresses entry 0; on a miss the evicted buffer is marked valid here, retagged in S_DONE
               if (idx_ff == '0 && !chk_vld_ff) begin
                  chk_vld_ff <= 1'b1;
                  idx_ff     <= (IDX_W+1)'(1);
                  if (rs_ff.status == ST_MISS) begin
                     rs_ff.buf_out <= 6'(buf_ff);
                     valid_ff[buf_ff] <= 1'b1;
                     ref_we_ff <= 1'b1;
                     ref_wa_ff <= buf_ff;
                     ref_wd_ff <= 8'd1;
                  end
               end else if (idx_ff[IDX_W]) begin
                  state_ff <= S_DONE;
               end else begin
                  chk_vld_ff <= 1'b1;
                  idx_ff     <= idx_ff + (IDX_W+1)'(1);
               end
            end
            S_RELRD: begin
               // tag and count of released buffer read this cycle, data next
               if (!chk_vld_ff && idx_ff == '0 && !got_ff) begin
                  got_ff <= 1'b1;
               end else if (!valid_ff[buf_ff] || ref_rd == 8'd0) begin
                  rs_ff.status <= ST_UNDERFLOW;
                  state_ff     <= S_DONE;
               end else begin
                  rs_ff.status <= ST_RELEASED;
                  ref_we_ff    <= 1'b1;
                  ref_wa_ff    <= buf_ff;
                  ref_wd_ff    <= ref_rd - 8'd1;
                  if (rq_ff.was_dirty) begin
                     rs_ff.write_req <= 1'b1;
                     rs_ff.req_dev   <= tag_rd[39:32];
                     rs_ff.req_block <= tag_rd[31:0];
                  end
                  if (ref_rd == 8'd1) begin
                     if (wait_ff != '0) begin
                        wait_ff <= wait_ff - WAIT_W'(1);
                        rs_ff.wake_one <= 1'b1;
                     end
                     idx_ff   <= '0;
                     state_ff <= S_PUSH;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end
            end
            S_PUSH: begin
               if (idx_ff[IDX_W]) begin
                  free_ff[buf_ff] <= 1'b1;
                  state_ff <= S_DONE;
               end else begin
                  chk_vld_ff <= 1'b1;
                  idx_ff     <= idx_ff + (IDX_W+1)'(1);
               end
            end
            S_DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // ---------------------------------------------------------------- checks
   `BBCD_ASSERT_IMPL(a_rsp_not_idle_start, clock, reset, rsp_valid, !busy, "result while busy")
   `BBCD_ASSERT_IMPL(a_used_bound, clock, reset, 1'b1, used_ff <= CNT_W'(NBUF), "used count over NBUF")
   `BBCD_ASSERT_IMPL(a_wait_bound, clock, reset, 1'b1, wait_ff <= WAIT_W'(MAX_WAITERS), "waiters over limit")
   `BBCD_ASSERT_NEXT(a_done_strobe, clock, reset, state_ff == S_DONE, rsp_valid, "no strobe after done")
   `BBCD_ASSERT_IMPL(a_free_unref, clock, reset, rsp_valid && rs_ff.read_req, !rs_ff.write_req, "read and write together")

endmodule

[tb/block_buffer_cache_directory_unit_test.sv]
// ----------------------------------------------------------------------------
// Buffer cache directory testbench
// Drives acquire and release items with random gaps, predicts each result
// from a behavioral copy of the directory and checks every field.
// ----------------------------------------------------------------------------
module block_buffer_cache_directory_unit_test;
   import bbcd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_item_type req_item;
   logic         rsp_valid;
   rsp_item_type rsp_item;

   block_buffer_cache_directory_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   always begin
      clock = 1'b0; #5;
      clock = 1'b1; #5;
   end

   // directory copy used for prediction
   logic [7:0]  dir_dev   [NBUF];
   logic [31:0] dir_blk   [NBUF];
   logic [7:0]  dir_cnt   [NBUF] = '{default: '0};
   bit          dir_valid [NBUF];
   int          dir_rank  [NBUF];
   bit          dir_free  [NBUF];
   int          dir_used;
   int          dir_waiters;

   req_item_type pending_items[$];
   rsp_item_type expected_rsps[$];
   int           error_count = 0;

   function automatic void free_take(int b);
      for (int i = 0; i < NBUF; i++)
         if (dir_free[i] && i != b && dir_rank[i] > dir_rank[b]) dir_rank[i]--;
      dir_free[b] = 0;
      dir_rank[b] = 0;
   endfunction

   function automatic void free_push(int b);
      for (int i = 0; i < NBUF; i++)
         if (dir_free[i]) dir_rank[i]++;
      dir_free[b] = 1;
      dir_rank[b] = 0;
   endfunction

   function automatic rsp_item_type directory_predict(req_item_type it);
      rsp_item_type r;
      int  b;
      int  best;
      bit  found;
      bit  got;
      r = '0;
      found = 0;
      got = 0;
      b = 0;
      best = 0;
      if (it.cmd == CMD_ACQUIRE) begin
         for (int i = 0; i < NBUF && !found; i++)
            if (dir_valid[i] && dir_dev[i] == it.dev_id && dir_blk[i] == it.block_no) begin
               found = 1;
               b = i;
            end
         if (found) begin
            r.buf_out = b[5:0];
            if (dir_cnt[b] >= COUNT_MAX) begin
               r.status = ST_OVERFLOW;
            end else begin
               if (dir_free[b]) free_take(b);
               dir_cnt[b]++;
               r.status = ST_HIT;
            end
         end else begin
            if (dir_used < NBUF) begin
               b = dir_used;
               dir_used++;
               got = 1;
            end else begin
               for (int i = 0; i < NBUF; i++)
                  if (dir_free[i] && (!got || dir_rank[i] > best)) begin
                     best = dir_rank[i];
                     b = i;
                     got = 1;
                  end
               if (got) free_take(b);
            end
            if (got) begin
               dir_dev[b]   = it.dev_id;
               dir_blk[b]   = it.block_no;
               dir_valid[b] = 1;
               dir_cnt[b]   = 8'd1;
               r.status     = ST_MISS;
               r.buf_out    = b[5:0];
               r.read_req   = 1'b1;
               r.req_dev    = it.dev_id;
               r.req_block  = it.block_no;
            end else begin
               if (dir_waiters < MAX_WAITERS) dir_waiters++;
               r.status = ST_NOBUF;
            end
         end
      end else begin
         b = it.buf_sel;
         r.buf_out = it.buf_sel;
         if (!dir_valid[b] || dir_cnt[b] == 8'd0) begin
            r.status = ST_UNDERFLOW;
         end else begin
            if (it.was_dirty) begin
               r.write_req = 1'b1;
               r.req_dev   = dir_dev[b];
               r.req_block = dir_blk[b];
            end
            dir_cnt[b]--;
            if (dir_cnt[b] == 8'd0) begin
               free_push(b);
               if (dir_waiters > 0) begin
                  dir_waiters--;
                  r.wake_one = 1'b1;
               end
            end
            r.status = ST_RELEASED;
         end
      end
      return r;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 40) return 0;
      if (p < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 300);
   endfunction

   // driver: changes inputs on the falling edge
   int drv_gap;

   always @(negedge clock) begin
      if (reset) begin
         start    <= 1'b0;
         req_item <= '0;
         drv_gap  <= 0;
      end else if (start) begin
         // busy was low when start rose, so the last rising edge took it
         start   <= 1'b0;
         drv_gap <= pick_gap();
      end else if (drv_gap > 0) begin
         drv_gap <= drv_gap - 1;
      end else if (pending_items.size() > 0 && !busy) begin
         req_item <= pending_items.pop_front();
         start    <= 1'b1;
      end
   end

   // acceptance seen on the rising edge
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         expected_rsps.push_back(directory_predict(req_item));
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: result with none expected, actual %p", $time, rsp_item);
            error_count++;
         end else begin
            rsp_item_type e;
            e = expected_rsps.pop_front();
            if (rsp_item !== e) begin
               $display("%0t: mismatch expected %p actual %p", $time, e, rsp_item);
               error_count++;
            end
         end
      end
   end

   function automatic req_item_type mk_acq(logic [7:0] d, logic [31:0] b);
      req_item_type it;
      it = '0;
      it.cmd = CMD_ACQUIRE;
      it.dev_id = d;
      it.block_no = b;
      it.buf_sel = 6'($urandom());
      it.was_dirty = 1'($urandom());
      return it;
   endfunction

   function automatic req_item_type mk_rel(logic [5:0] s, logic dty);
      req_item_type it;
      it = '0;
      it.cmd = CMD_RELEASE;
      it.dev_id = 8'($urandom());
      it.block_no = $urandom();
      it.buf_sel = s;
      it.was_dirty = dty;
      return it;
   endfunction

   // stimulus
   initial begin
      int n;
      int pool;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: underflow on unused, miss at extremes, hit, dirty release
      pending_items.push_back(mk_rel(6'd63, 1'b1));
      pending_items.push_back(mk_acq(8'hFF, 32'hFFFF_FFFF));
      pending_items.push_back(mk_acq(8'h00, 32'h0));
      pending_items.push_back(mk_acq(8'hFF, 32'hFFFF_FFFF));
      pending_items.push_back(mk_rel(6'd0, 1'b1));
      pending_items.push_back(mk_rel(6'd1, 1'b0));
      pending_items.push_back(mk_rel(6'd1, 1'b1));
      pending_items.push_back(mk_rel(6'd0, 1'b0));
      pending_items.push_back(mk_acq(8'h00, 32'h0));
      // overflow: drive one buffer to the count limit
      for (int i = 0; i < 256; i++) pending_items.push_back(mk_acq(8'h5A, 32'h1234_5678));
      for (int i = 0; i < 255; i++) pending_items.push_back(mk_rel(6'd2, i[0]));
      // fill all buffers, then starve: no buffer and waiter saturation
      for (int i = 0; i < NBUF + 18; i++) pending_items.push_back(mk_acq(8'h77, i + 100));
      // releases wake waiters, evictions follow in rank order
      for (int i = 0; i < NBUF; i++) pending_items.push_back(mk_rel(6'(i), 1'($urandom())));
      for (int i = 0; i < 20; i++) pending_items.push_back(mk_acq(8'h11, i));

      // random: small tag pool so hits, evictions and underflows recur
      n = 0;
      while (n < 414) begin
         pool = ($urandom_range(0, 3) == 0) ? 200 : 80;
         if ($urandom_range(0, 9) == 0)
            pending_items.push_back(mk_acq(8'($urandom()), $urandom()));
         else if ($urandom_range(0, 1))
            pending_items.push_back(mk_acq(8'($urandom_range(0, 3)), $urandom_range(0, pool)));
         else
            pending_items.push_back(mk_rel(6'($urandom()), 1'($urandom())));
         n++;
      end

      wait (pending_items.size() == 0 && !start);
      wait (expected_rsps.size() == 0);
      repeat (3 * NBUF + 20) @(posedge clock);
      if (error_count == 0 && expected_rsps.size() == 0) begin
         $display("block_buffer_cache_directory_unit_test: clean");
      end else begin
         $display("block_buffer_cache_directory_unit_test: errors");
      end
      $finish;
   end

   // watchdog: allows ~1100 items with their longest gaps, several times over
   initial begin
      #40_000_000;
      $display("block_buffer_cache_directory_unit_test: errors");
      $finish;
   end
endmodule
